/* hdl/pgsc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the packed glyph scaler and colorizer
package pgsc_pkg;

    // glyph store
    localparam int GLYPH_BYTES = 1024;
    localparam int GLYPH_AW    = $clog2(GLYPH_BYTES);

    // field widths
    localparam int SRC_W      = 7;
    localparam int COORD_W    = 10;
    localparam int ADDR_W     = 10;
    localparam int LB_W       = 4;
    localparam int LC_W       = 9;
    localparam int CH_W       = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RGB_W;

    // derived arithmetic widths
    localparam int PROD_W     = COORD_W + SRC_W;
    localparam int SRC_QW     = SRC_W;
    localparam int LIN_W      = 2 * SRC_W;
    localparam int BITPOS_W   = LIN_W + 3;
    localparam int NUM_W      = 2 * CH_W;
    localparam int GREY_STEPS = CH_W;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int CNT_W  = QAW + 1;

    localparam logic [CH_W-1:0] GREY_MAX = 8'd255;
    localparam int ALPHA_SHIFT = 8;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH   = 3'd0,
        REG_SRC_HEIGHT  = 3'd1,
        REG_LEVEL_BITS  = 3'd2,
        REG_LEVEL_COUNT = 3'd3,
        REG_DST_WIDTH   = 3'd4,
        REG_DST_HEIGHT  = 3'd5,
        REG_COLOR_RGB   = 3'd6,
        REG_COLOR_ALPHA = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic [SRC_W-1:0]   src_width;
        logic [SRC_W-1:0]   src_height;
        logic [LB_W-1:0]    level_bits;
        logic [LC_W-1:0]    level_count;
        logic [COORD_W-1:0] dst_width;
        logic [COORD_W-1:0] dst_height;
        logic [RGB_W-1:0]   color_rgb;
        logic [CH_W-1:0]    color_alpha;
    } cfg_t;

    typedef struct packed {
        logic              is_write;
        logic              outside;
        logic [ADDR_W-1:0] byte_addr;
        logic [CH_W-1:0]   byte_data;
        logic [SRC_W-1:0]  sx;
        logic [SRC_W-1:0]  sy;
    } qent_t;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } qstat_t;

endpackage

/* hdl/pgsc_front.sv */
`timescale 1ns / 1ps
// front part: accepts items, classifies them and maps target to source pixel
module pgsc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pgsc_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [pgsc_pkg::ADDR_W-1:0]   byte_addr,
    input  logic [pgsc_pkg::CH_W-1:0]     byte_data,
    input  logic [pgsc_pkg::COORD_W-1:0]  dst_x,
    input  logic [pgsc_pkg::COORD_W-1:0]  dst_y,
    input  logic                          q_full,
    output logic                          q_push,
    output pgsc_pkg::qent_t               q_push_ent
);

    localparam int NS = pgsc_pkg::SRC_QW + 1;
    localparam int PW = pgsc_pkg::PROD_W;

    typedef struct packed {
        logic                          is_write;
        logic                          outside;
        logic [pgsc_pkg::ADDR_W-1:0]   byte_addr;
        logic [pgsc_pkg::CH_W-1:0]     byte_data;
        logic [PW-1:0]                 rx;
        logic [PW-1:0]                 ry;
        logic [pgsc_pkg::SRC_W-1:0]    qx;
        logic [pgsc_pkg::SRC_W-1:0]    qy;
    } fr_t;

    fr_t           stg_reg  [NS];
    fr_t           stg_next [NS];
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic          adv;

    // whole front moves together, held only by a full queue
    assign adv      = !vld_reg[NS-1] || !q_full;
    assign in_ready = adv;
    assign vld_next = {vld_reg[NS-2:0], in_valid};

    always_comb
    begin
        logic [PW-1:0] trial_x;
        logic [PW-1:0] trial_y;
        trial_x = '0;
        trial_y = '0;

        // classify and form the scaled products
        stg_next[0].is_write  = (func == pgsc_pkg::FUNC_WRITE);
        stg_next[0].outside   = (func == pgsc_pkg::FUNC_RENDER)
                                && ((dst_x >= cfg.dst_width) || (dst_y >= cfg.dst_height));
        stg_next[0].byte_addr = byte_addr;
        stg_next[0].byte_data = byte_data;
        stg_next[0].rx        = PW'(dst_x) * PW'(cfg.src_width);
        stg_next[0].ry        = PW'(dst_y) * PW'(cfg.src_height);
        stg_next[0].qx        = '0;
        stg_next[0].qy        = '0;

        // one quotient bit per stage, msb first
        for (int s = 1; s < NS; s++)
        begin
            stg_next[s] = stg_reg[s-1];
            trial_x = PW'(cfg.dst_width) << (NS - 1 - s);
            trial_y = PW'(cfg.dst_height) << (NS - 1 - s);
            if (stg_reg[s-1].rx >= trial_x)
            begin
                stg_next[s].rx          = stg_reg[s-1].rx - trial_x;
                stg_next[s].qx[NS-1-s]  = 1'b1;
            end
            if (stg_reg[s-1].ry >= trial_y)
            begin
                stg_next[s].ry          = stg_reg[s-1].ry - trial_y;
                stg_next[s].qy[NS-1-s]  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stg_reg <= stg_next;
        end
    end

    assign q_push                = vld_reg[NS-1] && !q_full;
    assign q_push_ent.is_write   = stg_reg[NS-1].is_write;
    assign q_push_ent.outside    = stg_reg[NS-1].outside;
    assign q_push_ent.byte_addr  = stg_reg[NS-1].byte_addr;
    assign q_push_ent.byte_data  = stg_reg[NS-1].byte_data;
    assign q_push_ent.sx         = stg_reg[NS-1].qx;
    assign q_push_ent.sy         = stg_reg[NS-1].qy;

endmodule

/* hdl/pgsc_queue.sv */
`timescale 1ns / 1ps
// short fifo between front and back
module pgsc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pgsc_pkg::qent_t  push_ent,
    input  logic             pop,
    output pgsc_pkg::qent_t  head,
    output pgsc_pkg::qstat_t stat
);

    localparam int QA = pgsc_pkg::QAW;
    localparam int CW = pgsc_pkg::CNT_W;

    pgsc_pkg::qent_t ent_reg [pgsc_pkg::QDEPTH];
    logic [QA-1:0]   wr_ptr_reg;
    logic [QA-1:0]   wr_ptr_next;
    logic [QA-1:0]   rd_ptr_reg;
    logic [QA-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QA'(pgsc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QA'(pgsc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_ent;
        end
    end

    assign head       = ent_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(pgsc_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

/* hdl/pgsc_back.sv */
`timescale 1ns / 1ps
// back part: glyph store access, level extraction, grey scaling and coloring
module pgsc_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pgsc_pkg::cfg_t               cfg,
    input  pgsc_pkg::qent_t              q_head,
    input  pgsc_pkg::qstat_t             q_stat,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pgsc_pkg::CH_W-1:0]    red,
    output logic [pgsc_pkg::CH_W-1:0]    green,
    output logic [pgsc_pkg::CH_W-1:0]    blue,
    output logic [pgsc_pkg::CH_W-1:0]    alpha_out,
    output logic                         outside
);

    localparam int CW  = pgsc_pkg::CH_W;
    localparam int LW  = pgsc_pkg::LIN_W;
    localparam int BW  = pgsc_pkg::BITPOS_W;
    localparam int NW  = pgsc_pkg::NUM_W;
    localparam int GS  = pgsc_pkg::GREY_STEPS;
    localparam int LBW = pgsc_pkg::LB_W;
    localparam int LCW = pgsc_pkg::LC_W;
    // stage order: a, b, d0 .. d(GS), e
    localparam int NB  = GS + 4;
    localparam int EI  = NB - 1;

    typedef struct packed {
        logic                         is_write;
        logic                         outside;
        logic [pgsc_pkg::ADDR_W-1:0]  byte_addr;
        logic [CW-1:0]                byte_data;
        logic [LW-1:0]                lin;
    } a_t;

    typedef struct packed {
        logic       is_write;
        logic       outside;
        logic       in_store;
        logic       lb_ok;
        logic [2:0] off;
    } b_t;

    typedef struct packed {
        logic          is_write;
        logic          outside;
        logic          clamp;
        logic          zero;
        logic [NW-1:0] r;
        logic [CW-1:0] q;
    } d_t;

    typedef struct packed {
        logic          is_write;
        logic          outside;
        logic          grey_nz;
        logic [NW-1:0] prod;
    } e_t;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [CW-1:0] alpha;
        logic          outside;
    } pix_t;

    logic [CW-1:0]  store_mem [pgsc_pkg::GLYPH_BYTES];

    logic [NB-1:0]  vld_reg;
    logic [NB-1:0]  vld_next;
    a_t             a_reg;
    a_t             a_next;
    b_t             b_reg;
    b_t             b_next;
    logic [CW-1:0]  mem_q_reg;
    d_t             d_reg  [GS+1];
    d_t             d_next [GS+1];
    e_t             e_reg;
    e_t             e_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    pix_t           pix_reg;
    pix_t           pix_next;

    logic           adv;
    logic           load_out;
    logic           lb_ok;
    logic [1:0]     lsh;
    logic [BW-1:0]  bitpos;
    logic [LW-1:0]  sel_addr;
    logic           in_store;
    logic [LCW-1:0] den;

    // back stalls only when a result sits unread in the output register
    assign adv      = !vld_reg[EI] || e_reg.is_write || !out_valid_reg || out_ready;
    assign q_pop    = adv && !q_stat.empty;
    assign vld_next = {vld_reg[NB-2:0], !q_stat.empty};
    assign load_out = adv && vld_reg[EI] && !e_reg.is_write;
    assign den      = cfg.level_count - LCW'(1);

    // bits per pixel decode, widths other than 1, 2, 4 or 8 read as level zero
    always_comb
    begin
        lb_ok = 1'b1;
        lsh   = 2'd0;
        unique case (cfg.level_bits)
            LBW'(1): lsh = 2'd0;
            LBW'(2): lsh = 2'd1;
            LBW'(4): lsh = 2'd2;
            LBW'(8): lsh = 2'd3;
            default: lb_ok = 1'b0;
        endcase
    end

    // stage a: linear source pixel index
    always_comb
    begin
        a_next.is_write  = q_head.is_write;
        a_next.outside   = q_head.outside;
        a_next.byte_addr = q_head.byte_addr;
        a_next.byte_data = q_head.byte_data;
        a_next.lin       = LW'(q_head.sy) * LW'(cfg.src_width) + LW'(q_head.sx);
    end

    // stage b: byte address and store access
    assign bitpos   = BW'(a_reg.lin) << lsh;
    assign sel_addr = a_reg.is_write ? LW'(a_reg.byte_addr) : bitpos[BW-1:3];
    assign in_store = int'(sel_addr) < pgsc_pkg::GLYPH_BYTES;

    always_comb
    begin
        b_next.is_write = a_reg.is_write;
        b_next.outside  = a_reg.outside;
        b_next.in_store = in_store;
        b_next.lb_ok    = lb_ok;
        b_next.off      = bitpos[2:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[0])
        begin
            if (a_reg.is_write && in_store)
            begin
                store_mem[sel_addr[pgsc_pkg::GLYPH_AW-1:0]] <= a_reg.byte_data;
            end
            mem_q_reg <= store_mem[sel_addr[pgsc_pkg::GLYPH_AW-1:0]];
        end
    end

    // stage d0: level extraction, then one grey quotient bit per stage
    always_comb
    begin
        logic [CW-1:0]  src_byte;
        logic [LBW-1:0] shamt;
        logic [CW-1:0]  lmask;
        logic [CW-1:0]  level;
        logic [CW-1:0]  v;
        logic [NW-1:0]  num;
        logic [NW-1:0]  trial;
        src_byte = (b_reg.in_store && b_reg.lb_ok) ? mem_q_reg : '0;
        shamt    = LBW'(CW) - LBW'(b_reg.off) - cfg.level_bits;
        lmask    = CW'((LBW'(1) << cfg.level_bits) - LBW'(1));
        lmask    = CW'(((CW + 1)'(1) << cfg.level_bits) - (CW + 1)'(1));
        level    = (src_byte >> shamt) & lmask;
        v        = level & den[CW-1:0];
        num      = {v, CW'(0)} - NW'(v);
        trial    = '0;

        d_next[0].is_write = b_reg.is_write;
        d_next[0].outside  = b_reg.outside;
        d_next[0].zero     = (cfg.level_count < LCW'(2));
        d_next[0].clamp    = ({1'b0, num[NW-1:CW]} >= den);
        d_next[0].r        = num;
        d_next[0].q        = '0;

        for (int s = 1; s <= GS; s++)
        begin
            d_next[s] = d_reg[s-1];
            trial = NW'(den) << (GS - s);
            if (d_reg[s-1].r >= trial)
            begin
                d_next[s].r          = d_reg[s-1].r - trial;
                d_next[s].q[GS - s]  = 1'b1;
            end
        end
    end

    // stage e: grey with clamp, weighted alpha
    always_comb
    begin
        logic [CW-1:0] grey;
        if (d_reg[GS].zero)
        begin
            grey = '0;
        end
        else if (d_reg[GS].clamp)
        begin
            grey = pgsc_pkg::GREY_MAX;
        end
        else
        begin
            grey = d_reg[GS].q;
        end
        e_next.is_write = d_reg[GS].is_write;
        e_next.outside  = d_reg[GS].outside;
        e_next.grey_nz  = !d_reg[GS].outside && (grey != '0);
        e_next.prod     = NW'(grey) * NW'(cfg.color_alpha);
    end

    // output register
    always_comb
    begin
        pix_next.outside = e_reg.outside;
        if (e_reg.grey_nz)
        begin
            pix_next.red   = cfg.color_rgb[3*CW-1:2*CW];
            pix_next.green = cfg.color_rgb[2*CW-1:CW];
            pix_next.blue  = cfg.color_rgb[CW-1:0];
            pix_next.alpha = CW'(e_reg.prod >> pgsc_pkg::ALPHA_SHIFT);
        end
        else
        begin
            pix_next.red   = '0;
            pix_next.green = '0;
            pix_next.blue  = '0;
            pix_next.alpha = '0;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= vld_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            d_reg <= d_next;
            e_reg <= e_next;
        end
        if (load_out)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = pix_reg.red;
    assign green     = pix_reg.green;
    assign blue      = pix_reg.blue;
    assign alpha_out = pix_reg.alpha;
    assign outside   = pix_reg.outside;

endmodule

/* hdl/packed_glyph_scale_colorize.sv */
`timescale 1ns / 1ps
// top level of the packed glyph scaler and colorizer
//
// input channel (in_valid / in_ready): each item is either a glyph byte write
// (func = 0, byte_addr, byte_data) or a render of one target pixel (func = 1,
// dst_x, dst_y). a write gives no result; a render gives exactly one
// result item on the output channel (out_valid / out_ready): red, green, blue,
// alpha_out and outside, in the order the items came in.
// configuration: cfg_wr_en writes cfg_data into register cfg_index at the
// clock edge; write only while no item is in flight.
// throughput: one item per clock when out_ready stays high. with an idle
// receiver, a render item lands in the product stage when taken, then passes
// the coordinate division stages of the front (one quotient bit per stage),
// the queue, 12 back stages (index, store read, level extraction, 8 grey
// division steps, alpha multiply) and the output register.
// the front and back are split by a 4 entry queue: a stalled receiver holds
// the back, the queue fills, and only then does in_ready drop.
// reset clears all valid state and sets the configuration defaults; the
// glyph store is not cleared and reads undefined until written.
module packed_glyph_scale_colorize (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [pgsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pgsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic [pgsc_pkg::ADDR_W-1:0]       byte_addr,
    input  logic [pgsc_pkg::CH_W-1:0]         byte_data,
    input  logic [pgsc_pkg::COORD_W-1:0]      dst_x,
    input  logic [pgsc_pkg::COORD_W-1:0]      dst_y,
    // result items
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [pgsc_pkg::CH_W-1:0]         red,
    output logic [pgsc_pkg::CH_W-1:0]         green,
    output logic [pgsc_pkg::CH_W-1:0]         blue,
    output logic [pgsc_pkg::CH_W-1:0]         alpha_out,
    output logic                              outside
);

    pgsc_pkg::cfg_t   cfg_reg;
    pgsc_pkg::cfg_t   cfg_next;
    logic             q_push;
    logic             q_pop;
    pgsc_pkg::qent_t  q_push_ent;
    pgsc_pkg::qent_t  q_head;
    pgsc_pkg::qstat_t q_stat;

    // configuration registers, each field truncated to its width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (pgsc_pkg::cfg_reg_e'(cfg_index))
                pgsc_pkg::REG_SRC_WIDTH:
                    cfg_next.src_width   = cfg_data[pgsc_pkg::SRC_W-1:0];
                pgsc_pkg::REG_SRC_HEIGHT:
                    cfg_next.src_height  = cfg_data[pgsc_pkg::SRC_W-1:0];
                pgsc_pkg::REG_LEVEL_BITS:
                    cfg_next.level_bits  = cfg_data[pgsc_pkg::LB_W-1:0];
                pgsc_pkg::REG_LEVEL_COUNT:
                    cfg_next.level_count = cfg_data[pgsc_pkg::LC_W-1:0];
                pgsc_pkg::REG_DST_WIDTH:
                    cfg_next.dst_width   = cfg_data[pgsc_pkg::COORD_W-1:0];
                pgsc_pkg::REG_DST_HEIGHT:
                    cfg_next.dst_height  = cfg_data[pgsc_pkg::COORD_W-1:0];
                pgsc_pkg::REG_COLOR_RGB:
                    cfg_next.color_rgb   = cfg_data[pgsc_pkg::RGB_W-1:0];
                pgsc_pkg::REG_COLOR_ALPHA:
                    cfg_next.color_alpha = cfg_data[pgsc_pkg::CH_W-1:0];
            endcase
        end
    end

    // defaults: 16x16 source, 2 bit levels, 32x32 target, opaque white
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width   <= pgsc_pkg::SRC_W'(16);
            cfg_reg.src_height  <= pgsc_pkg::SRC_W'(16);
            cfg_reg.level_bits  <= pgsc_pkg::LB_W'(2);
            cfg_reg.level_count <= pgsc_pkg::LC_W'(4);
            cfg_reg.dst_width   <= pgsc_pkg::COORD_W'(32);
            cfg_reg.dst_height  <= pgsc_pkg::COORD_W'(32);
            cfg_reg.color_rgb   <= '1;
            cfg_reg.color_alpha <= '1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept, classify, nearest neighbor coordinate division
    pgsc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .byte_addr  (byte_addr),
        .byte_data  (byte_data),
        .dst_x      (dst_x),
        .dst_y      (dst_y),
        .q_full     (q_stat.full),
        .q_push     (q_push),
        .q_push_ent (q_push_ent)
    );

    // decoupling queue
    pgsc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_ent (q_push_ent),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    // back: store access, grey scaling, color and output register
    pgsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha_out (alpha_out),
        .outside   (outside)
    );

`ifndef ASSERT_OFF
    // front never pushes into a full queue
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue push while full");

    // back never pops an empty queue
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // an outside pixel is fully zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outside) |-> (red == '0 && green == '0 && blue == '0
                                    && alpha_out == '0))
        else $error("outside pixel not zero");
`endif

endmodule
